// ----- design/lzwd_pkg.sv -----
// ---------------------------------------------------------------------------
// lzwd_pkg
// Shared types and constants for the LZW decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package lzwd_pkg;

    localparam int BYTE_W   = 8;
    localparam int LITERALS = 256;

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP,
        S_LIT,
        S_APPEND,
        S_UPD,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

// ----- design/lzw_code_if.sv -----
// ---------------------------------------------------------------------------
// lzw_code_if
// Valid/ready channel carrying one compressed code and its restart flag.
// ---------------------------------------------------------------------------
`default_nettype none

interface lzw_code_if #(
    parameter int CODE_BITS = 12
) ();
    logic                 valid;
    logic                 ready;
    logic [CODE_BITS-1:0] code;
    logic                 restart;

    modport source (output valid, output code, output restart, input ready);
    modport sink   (input valid, input code, input restart, output ready);
endinterface

`default_nettype wire

// ----- design/lzw_byte_if.sv -----
// ---------------------------------------------------------------------------
// lzw_byte_if
// Valid/ready channel carrying one decoded byte with last and error flags.
// ---------------------------------------------------------------------------
`default_nettype none

interface lzw_byte_if import lzwd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last;
    logic              error;

    modport source (output valid, output out_byte, output last, output error, input ready);
    modport sink   (input valid, input out_byte, input last, input error, output ready);
endinterface

`default_nettype wire

// ----- design/lzw_decoder.sv -----
// A code of string length L is rebuilt on the byte stack and then played out;
// bytes then leave at one per cycle while the sink is ready.
// Each item takes up to L-1 reads along the prefix chain, one per cycle on the
// dictionary read port, then L byte stack reads, before a new code is taken.
// Reset (synchronous, active low) clears control state and the stream; the
// dictionary and byte stack are not cleared and need no clearing pass.
// ---------------------------------------------------------------------------
// lzw_decoder
// LZW decompressor: dictionary of prefix/suffix/length entries in one RAM,
// prefix chain walked into a byte stack, string played out per byte.
// ---------------------------------------------------------------------------
`default_nettype none

module lzw_decoder import lzwd_pkg::*; #(
    parameter int CODE_BITS  = 12,
    parameter int MAX_STRING = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lzw_code_if.sink   i_code_ch,
    lzw_byte_if.source o_byte_ch
);

    localparam int DICT_SIZE = 1 << CODE_BITS;
    localparam int LEN_W     = $clog2(MAX_STRING + 2);
    localparam int STK_AW    = $clog2(MAX_STRING);
    localparam int ENT_W     = CODE_BITS + BYTE_W + LEN_W;
    localparam int NFC_W     = CODE_BITS + 1;

    localparam logic [NFC_W-1:0] NFC_RESET = NFC_W'(LITERALS);
    localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_STRING);
    localparam logic [LEN_W-1:0] LEN_ONE   = LEN_W'(1);

    // dictionary: {prefix, suffix, length}
    logic [ENT_W-1:0] r_dict [DICT_SIZE];
    logic [ENT_W-1:0] r_dq;

    t_state               r_state, n_state;
    logic [NFC_W-1:0]     r_nfc, n_nfc;
    logic                 r_started, n_started;
    logic [CODE_BITS-1:0] r_prev, n_prev;
    logic [LEN_W-1:0]     r_prev_len, n_prev_len;
    logic [CODE_BITS-1:0] r_code, n_code;
    logic [CODE_BITS-1:0] r_cur, n_cur;
    logic [LEN_W-1:0]     r_pos, n_pos;
    logic [LEN_W-1:0]     r_len, n_len;
    logic [BYTE_W-1:0]    r_first, n_first;
    logic                 r_kwk, n_kwk;
    logic                 r_chk, n_chk;

    logic                 w_accept;
    logic [CODE_BITS-1:0] w_code;
    logic                 w_code_lit;
    logic                 w_eff_started;
    logic [NFC_W-1:0]     w_eff_nfc;
    logic [LEN_W-1:0]     w_kl;
    logic                 w_is_new;
    logic                 w_in_err;
    logic [CODE_BITS-1:0] w_start_cur;
    logic                 w_start_lit;
    logic [CODE_BITS-1:0] w_dq_pfx;
    logic [BYTE_W-1:0]    w_dq_sfx;
    logic [LEN_W-1:0]     w_dq_len;
    logic [LEN_W-1:0]     w_pos_now;
    logic [LEN_W-1:0]     w_step_pos;
    logic [LEN_W-1:0]     w_lit_pos;
    logic [LEN_W-1:0]     w_app_pos;
    logic                 w_step_err;
    logic                 w_pfx_lit;

    logic                 w_rd_en;
    logic [CODE_BITS-1:0] w_rd_addr;
    logic                 w_dict_we;
    logic [CODE_BITS-1:0] w_dict_addr;
    logic [ENT_W-1:0]     w_dict_data;

    logic                 w_stk_we;
    logic [STK_AW-1:0]    w_stk_addr;
    logic [BYTE_W-1:0]    w_stk_data;
    logic                 w_em_start;
    logic                 w_em_err;
    logic [LEN_W-1:0]     w_em_len;
    logic                 w_busy;

    assign i_code_ch.ready = (r_state == S_IDLE);
    assign w_accept        = i_code_ch.valid && i_code_ch.ready;
    assign w_code          = i_code_ch.code;

    always_comb begin
        w_code_lit    = (w_code[CODE_BITS-1:BYTE_W] == '0);
        w_eff_started = r_started && !i_code_ch.restart;
        w_eff_nfc     = i_code_ch.restart ? NFC_RESET : r_nfc;
        w_kl          = r_prev_len + LEN_ONE;
        w_is_new      = ({1'b0, w_code} == w_eff_nfc);
        if (!w_eff_started) begin
            w_in_err = !w_code_lit;
        end else begin
            w_in_err = ({1'b0, w_code} > w_eff_nfc) || (w_is_new && (w_kl > LEN_MAX));
        end
        w_start_cur = w_is_new ? r_prev : w_code;
        w_start_lit = (w_start_cur[CODE_BITS-1:BYTE_W] == '0);

        w_dq_pfx   = r_dq[ENT_W-1 -: CODE_BITS];
        w_dq_sfx   = r_dq[LEN_W +: BYTE_W];
        w_dq_len   = r_dq[LEN_W-1:0];
        w_pos_now  = r_chk ? w_dq_len : r_pos;
        w_step_pos = w_pos_now - LEN_ONE;
        w_lit_pos  = r_pos - LEN_ONE;
        w_app_pos  = r_len - LEN_ONE;
        w_step_err = r_chk && ((w_dq_len > LEN_MAX) || (w_dq_len == '0));
        w_pfx_lit  = (w_dq_pfx[CODE_BITS-1:BYTE_W] == '0);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_in_err || !w_eff_started) begin
                        n_state = S_EMIT;
                    end else if (w_start_lit) begin
                        n_state = S_LIT;
                    end else begin
                        n_state = S_STEP;
                    end
                end
            end
            S_STEP: begin
                if (w_step_err) begin
                    n_state = S_EMIT;
                end else if (w_pfx_lit) begin
                    n_state = S_LIT;
                end
            end
            S_LIT:    n_state = r_kwk ? S_APPEND : S_UPD;
            S_APPEND: n_state = S_UPD;
            S_UPD:    n_state = S_EMIT;
            S_EMIT: begin
                if (!w_busy) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_nfc       = r_nfc;
        n_started   = r_started;
        n_prev      = r_prev;
        n_prev_len  = r_prev_len;
        n_code      = r_code;
        n_cur       = r_cur;
        n_pos       = r_pos;
        n_len       = r_len;
        n_first     = r_first;
        n_kwk       = r_kwk;
        n_chk       = r_chk;
        w_rd_en     = 1'b0;
        w_rd_addr   = w_start_cur;
        w_dict_we   = 1'b0;
        w_dict_addr = r_nfc[CODE_BITS-1:0];
        w_dict_data = {r_prev, r_first, w_kl};
        w_stk_we    = 1'b0;
        w_stk_addr  = '0;
        w_stk_data  = w_code[BYTE_W-1:0];
        w_em_start  = 1'b0;
        w_em_err    = 1'b0;
        w_em_len    = r_len;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_nfc     = w_eff_nfc;
                    n_started = w_eff_started;
                    n_code    = w_code;
                    if (w_in_err) begin
                        w_em_start = 1'b1;
                        w_em_err   = 1'b1;
                    end else if (!w_eff_started) begin
                        w_stk_we   = 1'b1;
                        w_em_start = 1'b1;
                        w_em_len   = LEN_ONE;
                        n_started  = 1'b1;
                        n_prev     = w_code;
                        n_prev_len = LEN_ONE;
                    end else begin
                        n_cur   = w_start_cur;
                        n_kwk   = w_is_new;
                        n_chk   = !w_is_new && !w_code_lit;
                        n_pos   = w_is_new ? r_prev_len : LEN_ONE;
                        n_len   = w_is_new ? w_kl : LEN_ONE;
                        w_rd_en = !w_start_lit;
                    end
                end
            end
            S_STEP: begin
                if (w_step_err) begin
                    w_em_start = 1'b1;
                    w_em_err   = 1'b1;
                end else begin
                    w_stk_we   = 1'b1;
                    w_stk_addr = w_step_pos[STK_AW-1:0];
                    w_stk_data = w_dq_sfx;
                    n_pos      = w_step_pos;
                    if (r_chk) begin
                        n_len = w_dq_len;
                    end
                    n_chk     = 1'b0;
                    n_cur     = w_dq_pfx;
                    w_rd_en   = !w_pfx_lit;
                    w_rd_addr = w_dq_pfx;
                end
            end
            S_LIT: begin
                w_stk_we   = 1'b1;
                w_stk_addr = w_lit_pos[STK_AW-1:0];
                w_stk_data = r_cur[BYTE_W-1:0];
                n_first    = r_cur[BYTE_W-1:0];
            end
            S_APPEND: begin
                w_stk_we   = 1'b1;
                w_stk_addr = w_app_pos[STK_AW-1:0];
                w_stk_data = r_first;
            end
            S_UPD: begin
                if (!r_nfc[CODE_BITS]) begin
                    w_dict_we = 1'b1;
                    n_nfc     = r_nfc + NFC_W'(1);
                end
                n_prev     = r_code;
                n_prev_len = r_len;
                w_em_start = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_dict_we) begin
            r_dict[w_dict_addr] <= w_dict_data;
        end
        if (w_rd_en) begin
            r_dq <= r_dict[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_nfc      <= NFC_RESET;
            r_started  <= 1'b0;
            r_prev     <= '0;
            r_prev_len <= LEN_ONE;
        end else begin
            r_state    <= n_state;
            r_nfc      <= n_nfc;
            r_started  <= n_started;
            r_prev     <= n_prev;
            r_prev_len <= n_prev_len;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code  <= n_code;
        r_cur   <= n_cur;
        r_pos   <= n_pos;
        r_len   <= n_len;
        r_first <= n_first;
        r_kwk   <= n_kwk;
        r_chk   <= n_chk;
    end

    lzwd_emit #(
        .MAX_STRING (MAX_STRING),
        .LEN_W      (LEN_W),
        .STK_AW     (STK_AW)
    ) u_emit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_stk_we),
        .i_wr_addr (w_stk_addr),
        .i_wr_data (w_stk_data),
        .i_start   (w_em_start),
        .i_err     (w_em_err),
        .i_len     (w_em_len),
        .o_busy    (w_busy),
        .o_byte_ch (o_byte_ch)
    );

endmodule

`default_nettype wire

// ----- design/lzwd_emit.sv -----
// ---------------------------------------------------------------------------
// lzwd_emit
// Byte stack memory and output stage: holds one decoded string and plays it
// out in order, one transfer per byte, or a single error transfer.
// ---------------------------------------------------------------------------
`default_nettype none

module lzwd_emit import lzwd_pkg::*; #(
    parameter int MAX_STRING = 64,
    parameter int LEN_W      = $clog2(MAX_STRING + 2),
    parameter int STK_AW     = $clog2(MAX_STRING)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  logic [STK_AW-1:0] i_wr_addr,
    input  logic [BYTE_W-1:0] i_wr_data,
    input  logic              i_start,
    input  logic              i_err,
    input  logic [LEN_W-1:0]  i_len,
    output logic              o_busy,
    lzw_byte_if.source        o_byte_ch
);

    logic [BYTE_W-1:0] r_stack [MAX_STRING];
    logic [BYTE_W-1:0] r_mq;

    logic              r_busy;
    logic              r_sq_vld;
    logic              r_sq_last;
    logic              r_err;
    logic [LEN_W-1:0]  r_len;
    logic [LEN_W-1:0]  r_rk;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_last;
    logic              r_out_err;

    logic              w_load;
    logic              w_issue;
    logic [LEN_W-1:0]  n_rk;

    assign w_load  = r_sq_vld && (!r_out_valid || o_byte_ch.ready);
    assign w_issue = r_busy && (r_rk < r_len) && (!r_sq_vld || w_load);
    assign n_rk    = r_rk + LEN_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_stack[i_wr_addr] <= i_wr_data;
        end
        if (w_issue) begin
            r_mq <= r_stack[r_rk[STK_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_sq_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (w_load && r_sq_last) begin
                r_busy <= 1'b0;
            end
            if (w_issue) begin
                r_sq_vld <= 1'b1;
            end else if (w_load) begin
                r_sq_vld <= 1'b0;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_byte_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_len <= i_err ? LEN_W'(1) : i_len;
            r_err <= i_err;
            r_rk  <= '0;
        end else if (w_issue) begin
            r_rk <= n_rk;
        end
        if (w_issue) begin
            r_sq_last <= (n_rk == r_len);
        end
        if (w_load) begin
            r_out_byte <= r_err ? '0 : r_mq;
            r_out_last <= r_sq_last;
            r_out_err  <= r_err;
        end
    end

    assign o_busy             = r_busy;
    assign o_byte_ch.valid    = r_out_valid;
    assign o_byte_ch.out_byte = r_out_byte;
    assign o_byte_ch.last     = r_out_last;
    assign o_byte_ch.error    = r_out_err;

endmodule

`default_nettype wire

// ----- design/lzwd_checker.sv -----
// ---------------------------------------------------------------------------
// lzwd_checker
// Port-level checks of the LZW decoder, attached to the top level by bind.
// ---------------------------------------------------------------------------
`default_nettype none

module lzwd_checker import lzwd_pkg::*; (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              i_in_ready,
    input wire logic              i_out_valid,
    input wire logic              i_out_ready,
    input wire logic [BYTE_W-1:0] i_out_byte,
    input wire logic              i_out_last,
    input wire logic              i_out_error
);

    // stalled output transfer keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_byte) && $stable(i_out_last)
             && $stable(i_out_error)))
        else $error("output changed while stalled");

    // error result is a single zero byte marked last
    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_error) |-> (i_out_last && (i_out_byte == '0)))
        else $error("malformed error result");

    // one code at a time: input closes after each transfer
    a_in_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready held after transfer");

    // reset empties the output stage
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind lzw_decoder lzwd_checker u_lzwd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_code_ch.valid),
    .i_in_ready  (i_code_ch.ready),
    .i_out_valid (o_byte_ch.valid),
    .i_out_ready (o_byte_ch.ready),
    .i_out_byte  (o_byte_ch.out_byte),
    .i_out_last  (o_byte_ch.last),
    .i_out_error (o_byte_ch.error)
);

`default_nettype wire
